[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is evaluated at every edge, reset included.
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg
// Types, codes and helper functions of the sentence framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int unsigned LEN_W      = 11;
    localparam int unsigned MAXLEN_W   = 10;
    localparam int unsigned GLIM_W     = 5;
    localparam int unsigned GCNT_W     = 6;
    localparam int unsigned CHECK_W    = 16;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] PRINT_LOW    = 8'h20;
    localparam logic [7:0] PRINT_HIGH   = 8'h7E;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET    = 10'd1000;
    localparam logic [GLIM_W-1:0]   GARBAGE_LIMIT_RESET = 5'd16;

    typedef enum logic [0:0] {
        CFG_MAX_LENGTH    = 1'b0,
        CFG_GARBAGE_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_XOR_OK   = 3'd0,
        ST_CRC_OK   = 3'd1,
        ST_NO_STAR  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_ABORTED  = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       hash_as_star;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [LEN_W-1:0]   sentence_length;
        logic [CHECK_W-1:0] received_check;
        logic [CHECK_W-1:0] computed_check;
    } out_beat_t;

    typedef struct packed {
        logic [0:0]          index;
        logic [MAXLEN_W-1:0] data;
    } cfg_beat_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } nibble_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t n;
        n.valid = 1'b1;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n.value = 4'(c - 8'h57);
        end else begin
            n.valid = 1'b0;
        end
        return n;
    endfunction

endpackage

[hdl/sfc_stream_if.sv]
// ----------------------------------------------------------------------------
// sfc_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[hdl/sentence_framer_checksum_check.sv]
// ----------------------------------------------------------------------------
// sentence_framer_checksum_check
// Frames "$$...*check" sentences from a byte stream and checks the XOR or
// CRC-16 checksum, reporting one status beat per finished sentence.
// ----------------------------------------------------------------------------
//  channel      | dir | payload                                        | beat
//  byte_stream  | in  | rx_byte, hash_as_star                          | one byte
//  result       | out | status, sentence_length, received/computed chk | one sentence
//  cfg          | in  | index, data                                    | one register
//
//  Each byte is registered, then processed when the result side is free; one byte
//  per cycle while not stalled. Results are registered behind the byte register.
//  The byte register only advances when it is empty or the result register is empty or taken.
//  Reset clears the framing state and restores the register defaults.
//  Configuration beats are always accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sentence_framer_checksum_check (
    input  logic         clk,
    input  logic         rst_n,
    sfc_stream_if.sink   byte_stream,
    sfc_stream_if.source result,
    sfc_stream_if.sink   cfg
);

    logic [sfc_pkg::MAXLEN_W-1:0] max_length_reg;
    logic [sfc_pkg::GLIM_W-1:0]   garbage_limit_reg;

    logic                 s1_valid_reg;
    sfc_pkg::in_beat_t    s1_data_reg;
    logic                 adv;
    logic                 s1_fire;

    logic                 out_valid_reg;
    sfc_pkg::out_beat_t   out_data_reg;

    logic [7:0]                 prev_reg,        prev_next;
    logic                       in_sent_reg,     in_sent_next;
    logic [sfc_pkg::LEN_W-1:0]  length_reg,      length_next;
    logic [sfc_pkg::GCNT_W-1:0] garbage_reg,     garbage_next;
    logic [7:0]                 run_xor_reg,     run_xor_next;
    logic [15:0]                run_crc_reg,     run_crc_next;
    logic [7:0]                 star_xor_reg,    star_xor_next;
    logic [15:0]                star_crc_reg,    star_crc_next;
    logic                       star_seen_reg,   star_seen_next;
    logic [sfc_pkg::LEN_W-1:0]  digit_cnt_reg,   digit_cnt_next;
    logic [15:0]                digit_val_reg,   digit_val_next;
    logic                       all_hex_reg,     all_hex_next;

    logic                 emit;
    sfc_pkg::out_beat_t   res;
    logic [7:0]           b;
    sfc_pkg::nibble_t     nib;
    logic [15:0]          cc;

    assign cfg.ready         = 1'b1;
    assign adv               = !out_valid_reg || result.ready;
    assign s1_fire           = s1_valid_reg && adv;
    assign byte_stream.ready = !s1_valid_reg || adv;
    assign result.valid      = out_valid_reg;
    assign result.payload    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_length_reg    <= sfc_pkg::MAX_LENGTH_RESET;
            garbage_limit_reg <= sfc_pkg::GARBAGE_LIMIT_RESET;
        end else if (cfg.valid) begin
            unique case (sfc_pkg::cfg_index_t'(cfg.payload.index))
                sfc_pkg::CFG_MAX_LENGTH:    max_length_reg    <= cfg.payload.data;
                sfc_pkg::CFG_GARBAGE_LIMIT: garbage_limit_reg <= cfg.payload.data[sfc_pkg::GLIM_W-1:0];
                default:                    max_length_reg    <= max_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (byte_stream.ready) begin
            s1_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (byte_stream.ready && byte_stream.valid) begin
            s1_data_reg <= byte_stream.payload;
        end
    end

    always_comb begin
        b              = s1_data_reg.rx_byte;
        nib            = sfc_pkg::hex_nibble(8'h00);
        cc             = 16'h0000;
        emit           = 1'b0;
        res            = '0;
        in_sent_next   = in_sent_reg;
        length_next    = length_reg;
        garbage_next   = garbage_reg;
        run_xor_next   = run_xor_reg;
        run_crc_next   = run_crc_reg;
        star_xor_next  = star_xor_reg;
        star_crc_next  = star_crc_reg;
        star_seen_next = star_seen_reg;
        digit_cnt_next = digit_cnt_reg;
        digit_val_next = digit_val_reg;
        all_hex_next   = all_hex_reg;

        if (prev_reg == sfc_pkg::CHAR_DOLLAR && b == sfc_pkg::CHAR_DOLLAR) begin
            in_sent_next   = 1'b1;
            length_next    = sfc_pkg::LEN_W'(2);
            garbage_next   = '0;
            run_xor_next   = 8'h00;
            run_crc_next   = sfc_pkg::CRC_INIT;
            star_xor_next  = 8'h00;
            star_crc_next  = sfc_pkg::CRC_INIT;
            star_seen_next = 1'b0;
            digit_cnt_next = '0;
            digit_val_next = 16'h0000;
            all_hex_next   = 1'b1;
        end else if (in_sent_reg && b == sfc_pkg::CHAR_NEWLINE) begin
            emit                = 1'b1;
            in_sent_next        = 1'b0;
            res.sentence_length = length_reg + sfc_pkg::LEN_W'(1);
            if (!star_seen_reg) begin
                res.status = sfc_pkg::ST_NO_STAR;
            end else if (digit_cnt_reg != sfc_pkg::LEN_W'(2)
                         && digit_cnt_reg != sfc_pkg::LEN_W'(4)) begin
                res.status = sfc_pkg::ST_BAD_LEN;
            end else begin
                cc = (digit_cnt_reg == sfc_pkg::LEN_W'(2)) ? {8'h00, star_xor_reg}
                                                           : star_crc_reg;
                res.received_check = digit_val_reg;
                res.computed_check = cc;
                if (all_hex_reg && digit_val_reg == cc) begin
                    res.status = (digit_cnt_reg == sfc_pkg::LEN_W'(2)) ? sfc_pkg::ST_XOR_OK
                                                                        : sfc_pkg::ST_CRC_OK;
                end else begin
                    res.status = sfc_pkg::ST_MISMATCH;
                end
            end
        end else if (in_sent_reg) begin
            if (s1_data_reg.hash_as_star && b == sfc_pkg::CHAR_HASH) begin
                b = sfc_pkg::CHAR_STAR;
            end
            if (length_reg != '1) begin
                length_next = length_reg + sfc_pkg::LEN_W'(1);
            end
            if ((b < sfc_pkg::PRINT_LOW || b > sfc_pkg::PRINT_HIGH) && garbage_reg != '1) begin
                garbage_next = garbage_reg + sfc_pkg::GCNT_W'(1);
            end
            if (b == sfc_pkg::CHAR_STAR) begin
                star_xor_next  = run_xor_reg;
                star_crc_next  = run_crc_reg;
                star_seen_next = 1'b1;
                digit_cnt_next = '0;
                digit_val_next = 16'h0000;
                all_hex_next   = 1'b1;
            end else if (star_seen_reg) begin
                nib = sfc_pkg::hex_nibble(b);
                if (digit_cnt_reg != '1) begin
                    digit_cnt_next = digit_cnt_reg + sfc_pkg::LEN_W'(1);
                end
                if (!nib.valid) begin
                    all_hex_next = 1'b0;
                end
                digit_val_next = {digit_val_reg[11:0], nib.value};
            end
            run_xor_next = run_xor_reg ^ b;
            run_crc_next = sfc_pkg::crc_byte(run_crc_reg, b);
            if (length_next > {1'b0, max_length_reg}
                || garbage_next > {1'b0, garbage_limit_reg}) begin
                emit                = 1'b1;
                in_sent_next        = 1'b0;
                res.status          = sfc_pkg::ST_ABORTED;
                res.sentence_length = length_next;
            end
        end
        prev_next = b;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_reg      <= 8'h00;
            in_sent_reg   <= 1'b0;
            length_reg    <= '0;
            garbage_reg   <= '0;
            run_xor_reg   <= 8'h00;
            run_crc_reg   <= sfc_pkg::CRC_INIT;
            star_xor_reg  <= 8'h00;
            star_crc_reg  <= sfc_pkg::CRC_INIT;
            star_seen_reg <= 1'b0;
            digit_cnt_reg <= '0;
            digit_val_reg <= 16'h0000;
            all_hex_reg   <= 1'b1;
        end else if (s1_fire) begin
            prev_reg      <= prev_next;
            in_sent_reg   <= in_sent_next;
            length_reg    <= length_next;
            garbage_reg   <= garbage_next;
            run_xor_reg   <= run_xor_next;
            run_crc_reg   <= run_crc_next;
            star_xor_reg  <= star_xor_next;
            star_crc_reg  <= star_crc_next;
            star_seen_reg <= star_seen_next;
            digit_cnt_reg <= digit_cnt_next;
            digit_val_reg <= digit_val_next;
            all_hex_reg   <= all_hex_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_fire && emit) begin
            out_data_reg <= res;
        end
    end

    `SFC_ASSERT(a_s1_hold, clk, rst_n,
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_data_reg),
        "byte register changed while the result side was stalled")

    `SFC_ASSERT(a_result_source, clk, rst_n,
        $rose(out_valid_reg) |-> $past(s1_valid_reg),
        "result beat appeared without a registered byte behind it")

    `SFC_ASSERT(a_ok_matches, clk, rst_n,
        out_valid_reg && (out_data_reg.status == sfc_pkg::ST_XOR_OK
                          || out_data_reg.status == sfc_pkg::ST_CRC_OK)
            |-> out_data_reg.received_check == out_data_reg.computed_check,
        "checksum reported good while the values differ")

endmodule
